// File: src/apdc_pkg.sv
// shared constants and a text helper for the ide task-file device
package apdc_pkg;
   localparam int SECTOR_BYTES = 512;

   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_FILL  = 2'd2;

   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_WRITE = 2'd2;

   localparam logic [1:0] SRC_BUFFER = 2'd0;
   localparam logic [1:0] SRC_ONES   = 2'd1;
   localparam logic [1:0] SRC_IDENT  = 2'd2;

   localparam logic [1:0] MOP_NONE  = 2'd0;
   localparam logic [1:0] MOP_READ  = 2'd1;
   localparam logic [1:0] MOP_WRITE = 2'd2;

   localparam logic [7:0] CMD_READ     = 8'h20;
   localparam logic [7:0] CMD_WRITE    = 8'h30;
   localparam logic [7:0] CMD_VERIFY   = 8'h40;
   localparam logic [7:0] CMD_SET_MULT = 8'hc6;
   localparam logic [7:0] CMD_IDENTIFY = 8'hec;
   localparam logic [7:0] CMD_SET_FEAT = 8'hef;

   localparam logic [7:0] ERR_ABORT = 8'h04;

   localparam logic [3:0] OFF_DATA    = 4'd0;
   localparam logic [3:0] OFF_FEATURE = 4'd2;
   localparam logic [3:0] OFF_COUNT   = 4'd4;
   localparam logic [3:0] OFF_SECTOR  = 4'd6;
   localparam logic [3:0] OFF_CYL_LO  = 4'd8;
   localparam logic [3:0] OFF_CYL_HI  = 4'd10;
   localparam logic [3:0] OFF_DRVHEAD = 4'd12;
   localparam logic [3:0] OFF_COMMAND = 4'd14;

   localparam logic [1:0] CSR_PRESENT = 2'd0;
   localparam logic [1:0] CSR_CYL     = 2'd1;
   localparam logic [1:0] CSR_HEADS   = 2'd2;
   localparam logic [1:0] CSR_SPT     = 2'd3;

   // model text character, space padded
   function automatic logic [7:0] text_char(input logic [5:0] i);
      logic [7:0] c;
      c = 8'h20;
      unique case (i)
         6'd0: c = 8'h44;
         6'd1: c = 8'h55;
         6'd2: c = 8'h4d;
         6'd3: c = 8'h4d;
         6'd4: c = 8'h59;
         6'd5: c = 8'h20;
         6'd6: c = 8'h44;
         6'd7: c = 8'h52;
         6'd8: c = 8'h49;
         6'd9: c = 8'h56;
         6'd10: c = 8'h45;
         default: c = 8'h20;
      endcase
      return c;
   endfunction
endpackage

// File: src/apdc_ram.sv
// generic single-port ram with registered read
module apdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write or read one word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// File: src/apdc_ident.sv
// identify data byte generator
module apdc_ident
   import apdc_pkg::*;
(
   input  logic [8:0]  idx,
   input  logic [15:0] cylinder_total,
   input  logic [4:0]  heads,
   input  logic [5:0]  spt,
   output logic [7:0]  data
);
   logic [7:0]  w;
   logic [15:0] v;
   logic [5:0]  n;

   // pick the 16-bit identify word, then its byte
   always_comb begin
      w = idx[8:1];
      n = 6'(w - 8'd27);
      v = 16'h0000;
      if (w == 8'd0) begin
         v = 16'h8000;
      end else if (w == 8'd1) begin
         v = cylinder_total;
      end else if (w == 8'd3) begin
         v = {11'd0, heads};
      end else if (w == 8'd6) begin
         v = {10'd0, spt};
      end else if (w >= 8'd27 && w < 8'd47) begin
         v = {text_char({n[4:0], 1'b0}), text_char({n[4:0], 1'b1})};
      end
      data = idx[0] ? v[15:8] : v[7:0];
   end
endmodule

// File: src/ata_pio_disk_controller.sv
// top level of the ide task-file device with sector buffer
// each word passes the chs multiply stage, execute with the registered buffer read,
// and the result cycle, which gives its result strobe.
// busy is high from accept through the result cycle; no new word is taken until then.
// results cannot be held off by the receiver, so nothing ever stalls the sequence.
// synchronous reset returns task-file and control state to defaults; buffer is not cleared.
module ata_pio_disk_controller
   import apdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [3:0]  req_port_offset,
   input  logic [7:0]  req_wdata,
   input  logic        req_media_fail,
   output logic        rsp_valid,
   output logic [7:0]  rsp_rdata,
   output logic [1:0]  rsp_media_op,
   output logic [27:0] rsp_media_lba,
   output logic [8:0]  rsp_media_offset,
   output logic [7:0]  rsp_media_byte,
   output logic        rsp_media_device,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   localparam int PW = $clog2(SECTOR_BYTES);
   localparam logic [PW:0] FULL = (PW+1)'(SECTOR_BYTES);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;
   localparam logic [1:0] ST_RSP  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [1:0]  act_ff;
   logic [3:0]  off_ff;
   logic [7:0]  wd_ff;
   logic        fail_ff;

   logic [1:0]  present_ff, present_in;
   logic [15:0] cyltot_ff, cyltot_in;
   logic [4:0]  heads_ff, heads_in;
   logic [5:0]  spt_ff, spt_in;

   logic [7:0]  count_ff, sector_ff, error_ff, feature_ff;
   logic [7:0]  count_in, sector_in, error_in, feature_in;
   logic [15:0] cyl_ff, cyl_in;
   logic [3:0]  head_ff, head_in;
   logic        dev_ff, dev_in;
   logic [1:0]  mode_ff, src_ff, mode_in, src_in;
   logic [27:0] block_ff, block_in;
   logic [8:0]  left_ff, left_in;
   logic [PW:0] bptr_ff, fptr_ff, bptr_in, fptr_in;
   logic [20:0] prod_ff;
   logic [27:0] lba_ff;

   logic [7:0]  rdata_ff, rdata_in;
   logic [1:0]  mop_ff, mop_in;
   logic [27:0] mlba_ff, mlba_in;
   logic [8:0]  moff_ff, moff_in;
   logic [7:0]  mbyte_ff, mbyte_in;
   logic        mdev_ff, mdev_in;
   logic        rv_ff, rv_in;

   logic        ram_we;
   logic [PW-1:0] ram_addr;
   logic [7:0]  ram_q, ident_q;
   logic        drive_ok;

   assign drive_ok  = present_ff[dev_ff];
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);

   // in execute the fill pointer addresses the buffer (fill writes there), otherwise the data pointer for read
   assign ram_we   = (state_ff == ST_EXEC) && (act_ff == ACT_FILL) && (fptr_ff < FULL);
   assign ram_addr = (state_ff == ST_EXEC) ? fptr_ff[PW-1:0] : bptr_ff[PW-1:0];

   apdc_ram #(.WIDTH(8), .DEPTH(SECTOR_BYTES)) u_buf (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (wd_ff),
      .rd_data (ram_q)
   );

   apdc_ident u_ident (
      .idx            (bptr_ff[8:0]),
      .cylinder_total (cyltot_ff),
      .heads          (heads_ff),
      .spt            (spt_ff),
      .data           (ident_q)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_MUL;
         ST_MUL:  state_in = ST_EXEC;
         ST_EXEC: state_in = ST_RSP;
         ST_RSP:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // capture request word
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         act_ff  <= req_action;
         off_ff  <= req_port_offset;
         wd_ff   <= req_wdata;
         fail_ff <= req_media_fail;
      end
   end

   // chs to lba in two registered multiply steps
   always_ff @(posedge clock) begin
      prod_ff <= 21'(cyl_ff) * 21'(heads_ff) + 21'(head_ff);
      lba_ff  <= 28'(27'(prod_ff) * 27'(spt_ff)) + 28'(sector_ff) - 28'd1;
   end

   // main execute step, next state
   always_comb begin
      logic [PW:0] bnext;
      logic [8:0]  lnext;
      logic        done;
      logic        restart;
      present_in = present_ff; cyltot_in = cyltot_ff; heads_in = heads_ff; spt_in = spt_ff;
      count_in = count_ff; sector_in = sector_ff; error_in = error_ff;
      feature_in = feature_ff; cyl_in = cyl_ff; head_in = head_ff; dev_in = dev_ff;
      mode_in = mode_ff; src_in = src_ff; block_in = block_ff; left_in = left_ff;
      bptr_in = bptr_ff; fptr_in = fptr_ff;
      rdata_in = rdata_ff; mop_in = mop_ff; mlba_in = mlba_ff;
      moff_in = moff_ff; mbyte_in = mbyte_ff; mdev_in = mdev_ff;
      rv_in = 1'b0;
      bnext = bptr_ff + 1'b1;
      lnext = left_ff - 9'd1;
      done = 1'b0;
      restart = 1'b0;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PRESENT: present_in = csr_wdata[1:0];
            CSR_CYL:     cyltot_in  = csr_wdata;
            CSR_HEADS:   heads_in   = csr_wdata[4:0];
            CSR_SPT:     spt_in     = csr_wdata[5:0];
            default: ;
         endcase
      end
      if (state_ff == ST_EXEC) begin
         rv_in = 1'b1;
         rdata_in = '0; mop_in = MOP_NONE; mlba_in = '0;
         moff_in = '0; mbyte_in = '0; mdev_in = 1'b0;
         unique case (act_ff)
            ACT_WRITE: begin
               unique case (off_ff)
                  OFF_DATA: if (mode_ff == MODE_WRITE && bptr_ff < FULL) begin
                     if (drive_ok) begin
                        mop_in = MOP_WRITE; mlba_in = block_ff;
                        moff_in = bptr_ff[8:0]; mbyte_in = wd_ff; mdev_in = dev_ff;
                     end
                     bptr_in = bnext;
                     done = (bnext == FULL);
                  end
                  OFF_FEATURE: feature_in = wd_ff;
                  OFF_COUNT:   count_in = wd_ff;
                  OFF_SECTOR:  sector_in = wd_ff;
                  OFF_CYL_LO:  cyl_in[7:0] = wd_ff;
                  OFF_CYL_HI:  cyl_in[15:8] = wd_ff;
                  OFF_DRVHEAD: begin dev_in = wd_ff[4]; head_in = wd_ff[3:0]; end
                  OFF_COMMAND: begin
                     unique case (wd_ff)
                        CMD_READ: begin
                           block_in = lba_ff;
                           left_in = (count_ff == 8'd0) ? 9'd256 : {1'b0, count_ff};
                           mode_in = MODE_READ; error_in = '0;
                           bptr_in = '0;
                           if (drive_ok) begin
                              src_in = SRC_BUFFER; fptr_in = '0;
                              mop_in = MOP_READ; mlba_in = lba_ff; mdev_in = dev_ff;
                           end else begin
                              src_in = SRC_ONES; fptr_in = FULL;
                           end
                        end
                        CMD_WRITE: begin
                           block_in = lba_ff;
                           left_in = (count_ff == 8'd0) ? 9'd256 : {1'b0, count_ff};
                           mode_in = MODE_WRITE; bptr_in = '0; fptr_in = FULL;
                           error_in = '0;
                        end
                        CMD_VERIFY: error_in = '0;
                        CMD_SET_MULT: error_in = (count_ff <= 8'd1) ? 8'd0 : ERR_ABORT;
                        CMD_IDENTIFY: if (drive_ok) begin
                           src_in = SRC_IDENT; bptr_in = '0; fptr_in = FULL;
                           left_in = 9'd1; mode_in = MODE_READ; error_in = '0;
                        end else begin
                           error_in = ERR_ABORT;
                        end
                        CMD_SET_FEAT: ;
                        default: error_in = ERR_ABORT;
                     endcase
                  end
                  default: ;
               endcase
            end
            ACT_READ: begin
               if (off_ff == OFF_DATA) begin
                  if (mode_ff == MODE_READ && bptr_ff < FULL && fptr_ff == FULL) begin
                     unique case (src_ff)
                        SRC_IDENT: rdata_in = ident_q;
                        SRC_ONES:  rdata_in = 8'hff;
                        default:   rdata_in = ram_q;
                     endcase
                     bptr_in = bnext;
                     done = (bnext == FULL);
                  end
               end else if (off_ff == OFF_COMMAND) begin
                  rdata_in = {1'b0, drive_ok, 2'b00,
                              (bptr_ff < FULL && fptr_ff == FULL), 2'b00, (error_ff != 8'd0)};
               end
            end
            ACT_FILL: begin
               if (fptr_ff < FULL) begin
                  if (fail_ff) src_in = SRC_ONES;
                  fptr_in = fptr_ff + 1'b1;
               end
            end
            default: ;
         endcase
         // end of sector
         if (done) begin
            left_in = lnext;
            if (lnext != 9'd0) begin
               block_in = block_ff + 28'd1;
               bptr_in = '0;
               restart = (mode_ff == MODE_READ);
            end else begin
               mode_in = MODE_IDLE;
            end
         end
         if (restart) begin
            if (drive_ok) begin
               src_in = SRC_BUFFER; fptr_in = '0;
               mop_in = MOP_READ; mlba_in = block_ff + 28'd1; mdev_in = dev_ff;
            end else begin
               src_in = SRC_ONES; fptr_in = FULL;
            end
         end
      end
   end

   // control and task-file registers
   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= 2'd1; cyltot_ff <= 16'd615; heads_ff <= 5'd6; spt_ff <= 6'd17;
         count_ff <= '0; sector_ff <= '0; error_ff <= '0; feature_ff <= '0;
         cyl_ff <= '0; head_ff <= '0; dev_ff <= 1'b0;
         mode_ff <= MODE_IDLE; src_ff <= SRC_BUFFER; block_ff <= '0; left_ff <= '0;
         bptr_ff <= FULL; fptr_ff <= FULL; rv_ff <= 1'b0;
         rdata_ff <= '0; mop_ff <= MOP_NONE; mlba_ff <= '0;
         moff_ff <= '0; mbyte_ff <= '0; mdev_ff <= 1'b0;
      end else begin
         present_ff <= present_in; cyltot_ff <= cyltot_in;
         heads_ff <= heads_in; spt_ff <= spt_in;
         count_ff <= count_in; sector_ff <= sector_in; error_ff <= error_in;
         feature_ff <= feature_in; cyl_ff <= cyl_in; head_ff <= head_in; dev_ff <= dev_in;
         mode_ff <= mode_in; src_ff <= src_in; block_ff <= block_in; left_ff <= left_in;
         bptr_ff <= bptr_in; fptr_ff <= fptr_in; rv_ff <= rv_in;
         rdata_ff <= rdata_in; mop_ff <= mop_in; mlba_ff <= mlba_in;
         moff_ff <= moff_in; mbyte_ff <= mbyte_in; mdev_ff <= mdev_in;
      end
   end

   assign rsp_valid        = rv_ff;
   assign rsp_rdata        = rdata_ff;
   assign rsp_media_op     = mop_ff;
   assign rsp_media_lba    = mlba_ff;
   assign rsp_media_offset = moff_ff;
   assign rsp_media_byte   = mbyte_ff;
   assign rsp_media_device = mdev_ff;

`ifndef NO_ASSERTIONS
   // one result for each accepted word, in the fixed slot
   a_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid) else $error("missing result");
   // no result without a word in flight
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_EXEC)) else $error("stray result");
   // fill and data pointers never pass the sector size
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      bptr_ff <= FULL && fptr_ff <= FULL) else $error("pointer overrun");
   // media lba is zero in a result without a media operation
   a_mop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_media_op == MOP_NONE) |-> (rsp_media_lba == '0))
      else $error("media fields without op");
`endif
endmodule
